@@ design/bmd_pkg.sv @@
package bmd_pkg;

  localparam int unsigned SampleBits = 10;
  localparam int unsigned DutyBits   = 8;

  localparam logic [7:0] KeyMode = 8'h23;
  localparam logic [DutyBits-1:0] DutyFull = 8'd255;
  localparam logic [DutyBits-1:0] DutyZero = 8'd0;

  localparam logic [7:0] LockoutTicksRst    = 8'd10;
  localparam logic [6:0] FadeStepRst        = 7'd15;
  localparam logic [7:0] BrightThresholdRst = 8'd245;
  localparam logic [7:0] DimThresholdRst    = 8'd50;
  localparam logic [7:0] BandLowRst         = 8'd60;
  localparam logic [7:0] BandHighRst        = 8'd235;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_ON   = 2'd1,
    MODE_AUTO = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    REG_LOCKOUT_TICKS    = 3'd0,
    REG_FADE_STEP        = 3'd1,
    REG_BRIGHT_THRESHOLD = 3'd2,
    REG_DIM_THRESHOLD    = 3'd3,
    REG_BAND_LOW         = 3'd4,
    REG_BAND_HIGH        = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]            key_code;
    logic [SampleBits-1:0] light_sample;
  } in_item_t;

  typedef struct packed {
    logic [DutyBits-1:0] pwm_duty;
    logic [1:0]          mode;
  } out_item_t;

endpackage

@@ design/backlight_mode_dimmer.sv @@
// A result item is registered and presented in the cycle after its input item is accepted.
// Throughput: one item per cycle; ready follows the single output register, so a
// new item is taken whenever the result register is empty or being drained.
// Reset: mode on, duty 255, lockout count 0, configuration registers at defaults;
// no clearing pass, the block accepts items right after reset.
module backlight_mode_dimmer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bmd_pkg::in_item_t    in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bmd_pkg::out_item_t   out_item_o
);

  logic [7:0] lockout_ticks_q;
  logic [6:0] fade_step_q;
  logic [7:0] bright_q;
  logic [7:0] dim_q;
  logic [7:0] band_low_q;
  logic [7:0] band_high_q;

  bmd_pkg::mode_e mode_q, mode_d;
  logic [7:0] duty_q, duty_d;
  logic [7:0] lockout_q, lockout_d;
  logic       out_valid_q;
  bmd_pkg::out_item_t out_item_q;

  logic       accept;
  logic [7:0] lock_dec;
  logic [7:0] light;
  logic [7:0] step;
  logic [7:0] duty_inv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lockout_ticks_q <= bmd_pkg::LockoutTicksRst;
      fade_step_q     <= bmd_pkg::FadeStepRst;
      bright_q        <= bmd_pkg::BrightThresholdRst;
      dim_q           <= bmd_pkg::DimThresholdRst;
      band_low_q      <= bmd_pkg::BandLowRst;
      band_high_q     <= bmd_pkg::BandHighRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bmd_pkg::REG_LOCKOUT_TICKS:    lockout_ticks_q <= cfg_data_i;
        bmd_pkg::REG_FADE_STEP:        fade_step_q     <= cfg_data_i[6:0];
        bmd_pkg::REG_BRIGHT_THRESHOLD: bright_q        <= cfg_data_i;
        bmd_pkg::REG_DIM_THRESHOLD:    dim_q           <= cfg_data_i;
        bmd_pkg::REG_BAND_LOW:         band_low_q      <= cfg_data_i;
        bmd_pkg::REG_BAND_HIGH:        band_high_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;

  assign light    = in_item_i.light_sample[bmd_pkg::SampleBits-1 -: 8];
  assign step     = {1'b0, fade_step_q};
  assign lock_dec = (lockout_q != 8'd0) ? lockout_q - 8'd1 : 8'd0;
  assign duty_inv = bmd_pkg::DutyFull - step;

  always_comb begin
    mode_d    = mode_q;
    lockout_d = lock_dec;
    duty_d    = duty_q;
    if (in_item_i.key_code == bmd_pkg::KeyMode && lock_dec == 8'd0) begin
      lockout_d = lockout_ticks_q;
      unique case (mode_q)
        bmd_pkg::MODE_OFF: mode_d = bmd_pkg::MODE_ON;
        bmd_pkg::MODE_ON:  mode_d = bmd_pkg::MODE_AUTO;
        default:           mode_d = bmd_pkg::MODE_OFF;
      endcase
    end
    unique case (mode_d)
      bmd_pkg::MODE_OFF: begin
        if (duty_q <= step) begin
          duty_d = bmd_pkg::DutyZero;
        end else begin
          duty_d = duty_q - step;
        end
      end
      bmd_pkg::MODE_ON: begin
        if (duty_q >= duty_inv) begin
          duty_d = bmd_pkg::DutyFull;
        end else begin
          duty_d = duty_q + step;
        end
      end
      bmd_pkg::MODE_AUTO: begin
        if (light >= bright_q) begin
          duty_d = bmd_pkg::DutyFull;
        end else if (light <= dim_q) begin
          duty_d = dim_q;
        end else if (light < band_high_q && light > band_low_q) begin
          duty_d = light;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= bmd_pkg::MODE_ON;
      duty_q      <= bmd_pkg::DutyFull;
      lockout_q   <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        mode_q      <= mode_d;
        duty_q      <= duty_d;
        lockout_q   <= lockout_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q.pwm_duty <= duty_d;
      out_item_q.mode     <= mode_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  a_idle_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(mode_q) && $stable(duty_q) && $stable(lockout_q))
    else $error("state changed without an item");

  a_lockout_counts_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && lockout_q > 8'd1 |=> lockout_q == $past(lockout_q) - 8'd1)
    else $error("lockout counter did not count down");

  a_mode_needs_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_item_i.key_code != bmd_pkg::KeyMode |=> mode_q == $past(mode_q))
    else $error("mode changed without mode key");

  a_off_never_brightens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && mode_d == bmd_pkg::MODE_OFF |=> duty_q <= $past(duty_q))
    else $error("duty rose in off mode");

  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_item_q.pwm_duty == duty_q && out_item_q.mode == mode_q)
    else $error("result item differs from state");
`endif

endmodule
